// ----- design/buddy_frame_allocator_unit_macros.svh -----
// Assertion macros used by the allocator sequencer (bfa_ctrl).
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef BUDDY_FRAME_ALLOCATOR_UNIT_MACROS_SVH
`define BUDDY_FRAME_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, off during reset.
`define BFA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define BFA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/bfa_pkg.sv -----
// Package for the buddy frame allocator: widths, codes, state and command types.
// No dependencies; imported by every allocator module.
`default_nettype none
package bfa_pkg;

    localparam int MAX_ORDER_DEF   = 10;
    localparam int STACK_DEPTH_DEF = 1024;
    localparam int FRAME_BITS_DEF  = 20;

    localparam int FRAME_W   = 20;
    localparam int COUNT_W   = 21;
    localparam int TYPE_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int CFG_W     = 8;
    localparam int TDATA_W   = 48;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;
    localparam int REG_LSB   = 2;

    localparam logic [CFG_W-1:0] KEEP_RESET = 8'd8;
    localparam logic [CFG_W-1:0] TIDY_RESET = 8'd32;

    localparam logic REG_KEEP = 1'b0;
    localparam logic REG_TIDY = 1'b1;

    typedef enum logic [TYPE_W-1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_ADD   = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_ZERO  = 2'd1,
        ST_NOMEM = 2'd2,
        ST_OVF   = 2'd3
    } t_status;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic push;
        logic pop;
        logic wr;
        logic rd;
        logic setcnt;
    } t_stk_cmd;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ORD,
        S_SRCH,
        S_POP,
        S_POPW,
        S_SPLIT,
        S_TAIL1,
        S_TAIL2,
        S_RC1,
        S_RC2,
        S_RC3,
        S_PUSHF,
        S_SUBN,
        S_POST,
        S_POST2,
        S_TC_RD,
        S_TC_WR,
        S_TS_LD,
        S_TS_V,
        S_TS_CMP,
        S_TS_CHK,
        S_TM_RD,
        S_TM_A,
        S_TM_B,
        S_TR_RD,
        S_TR_WR,
        S_TW_RD,
        S_TW_WR,
        S_FIN
    } t_state;

endpackage
`default_nettype wire

// ----- design/buddy_frame_allocator_unit.sv -----
// Buddy frame allocator top level: stream ports, APB register file and result register.
// Depends on bfa_pkg and bfa_ctrl (which holds bfa_stack and bfa_alu).
//
// Requests enter on s_axis one at a time and each gives one result on m_axis. A zero,
// unknown-type or oversize request goes straight to its result, while a typical allocate,
// free or add walks the stacks. Every block pushed by recycle also uses the shared adder
// in S_PUSHF and S_SUBN, split pushes one block per order that it steps down, split walks
// the orders once and recycle walks them up and then down. A free that triggers a tidy
// also copies, insertion-sorts, merges and writes back that order's stack through
// single-port RAMs, a cost that grows with the entries on that stack. The stack RAM needs
// no clearing pass after reset; the block is ready as soon as reset ends.
// A finished result waits in the output register while the next request is taken.
`default_nettype none
module buddy_frame_allocator_unit import bfa_pkg::*; #(
    parameter int MAX_ORDER   = MAX_ORDER_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int FRAME_BITS  = FRAME_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [TDATA_W-1:0]  s_axis_tdata,   // frame[19:0], count[40:20], zero[47:41]
    input  logic [TYPE_W-1:0]   s_axis_tuser,   // req_type[1:0]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [TDATA_W-1:0]  m_axis_tdata,   // frame_out[19:0], frames_free[40:20], zero[47:41]
    output logic [STATUS_W-1:0] m_axis_tuser,   // status[1:0]
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    logic [CFG_W-1:0]    r_keep;
    logic [CFG_W-1:0]    r_tidy;
    logic                r_ovalid;
    logic [TDATA_W-1:0]  r_otdata;
    logic [STATUS_W-1:0] r_otuser;
    logic                idle;
    logic                start;
    logic                done;
    logic                res_ready;
    logic                cfg_wr;
    t_status             res_status;
    logic [FRAME_W-1:0]  res_frame;
    logic [COUNT_W-1:0]  res_free;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign start     = s_axis_tvalid && s_axis_tready;
    assign res_ready = !r_ovalid || m_axis_tready;

    always_comb begin
        case (paddr[REG_LSB])
            REG_TIDY: prdata = APB_DW'(r_tidy);
            default:  prdata = APB_DW'(r_keep);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= KEEP_RESET;
            r_tidy <= TIDY_RESET;
        end else if (cfg_wr) begin
            case (paddr[REG_LSB])
                REG_TIDY: r_tidy <= pwdata[CFG_W-1:0];
                default:  r_keep <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    bfa_ctrl #(
        .MAX_ORDER   (MAX_ORDER),
        .STACK_DEPTH (STACK_DEPTH),
        .FRAME_BITS  (FRAME_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_type      (s_axis_tuser),
        .i_frame     (s_axis_tdata[FRAME_W-1:0]),
        .i_count     (s_axis_tdata[FRAME_W+COUNT_W-1:FRAME_W]),
        .i_keep      (r_keep),
        .i_tidy_int  (r_tidy),
        .i_res_ready (res_ready),
        .o_idle      (idle),
        .o_done      (done),
        .o_status    (res_status),
        .o_frame     (res_frame),
        .o_free      (res_free)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (done) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_otdata <= TDATA_W'({res_free, res_frame});
            r_otuser <= res_status;
        end
    end

    assign s_axis_tready = idle && i_rst_n;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_otdata;
    assign m_axis_tuser  = r_otuser;

endmodule
`default_nettype wire

// ----- design/bfa_alu.sv -----
// Shared adder/subtractor used by the allocator sequencer for the frame and frame-count sums.
// Depends on bfa_pkg for the operation code.
`default_nettype none
module bfa_alu import bfa_pkg::*; #(
    parameter int AW = COUNT_W + 1
) (
    input  t_alu_op       i_op,
    input  logic [AW-1:0] i_a,
    input  logic [AW-1:0] i_b,
    output logic [AW-1:0] o_y
);

    always_comb begin
        case (i_op)
            ALU_SUB: o_y = i_a - i_b;
            default: o_y = i_a + i_b;
        endcase
    end

endmodule
`default_nettype wire

// ----- design/bfa_stack.sv -----
// Per-order free block stacks: one single-port-write RAM split by order, plus fill counts.
// Depends on bfa_pkg for the stack command struct.
`default_nettype none
module bfa_stack import bfa_pkg::*; #(
    parameter int MAX_ORDER   = MAX_ORDER_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int FRAME_BITS  = FRAME_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  t_stk_cmd                             i_cmd,
    input  logic [$clog2(MAX_ORDER+2)-1:0]       i_order,
    input  logic [$clog2(STACK_DEPTH)-1:0]       i_idx,
    input  logic [FRAME_BITS-1:0]                i_data,
    input  logic [$clog2(STACK_DEPTH+1)-1:0]     i_cnt,
    output logic [FRAME_BITS-1:0]                o_rdata,
    output logic [$clog2(STACK_DEPTH+1)-1:0]     o_cnt,
    output logic                                 o_full
);

    localparam int NUM_ORD = MAX_ORDER + 1;
    localparam int OW      = $clog2(MAX_ORDER + 2);
    localparam int IW      = $clog2(STACK_DEPTH);
    localparam int CW      = $clog2(STACK_DEPTH + 1);

    logic [FRAME_BITS-1:0] r_mem [NUM_ORD * (2 ** IW)];
    logic [FRAME_BITS-1:0] r_rdata;
    logic [CW-1:0]         r_cnt [NUM_ORD];
    logic [CW-1:0]         cur;
    logic [CW-1:0]         cur_m1;
    logic                  full;
    logic                  we;
    logic                  re;
    logic [OW+IW-1:0]      waddr;
    logic [OW+IW-1:0]      raddr;

    always_comb begin
        cur    = (i_order <= OW'(MAX_ORDER)) ? r_cnt[i_order] : '0;
        cur_m1 = cur - CW'(1);
        full   = cur >= CW'(STACK_DEPTH);
        we     = (i_cmd.push && !full) || i_cmd.wr;
        re     = i_cmd.pop || i_cmd.rd;
        waddr  = {i_order, (i_cmd.push ? cur[IW-1:0] : i_idx)};
        raddr  = {i_order, (i_cmd.pop ? cur_m1[IW-1:0] : i_idx)};
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= i_data;
        end
        if (re) begin
            r_rdata <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_ORD; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (i_cmd.push && !full) begin
            r_cnt[i_order] <= cur + CW'(1);
        end else if (i_cmd.pop) begin
            r_cnt[i_order] <= cur_m1;
        end else if (i_cmd.setcnt) begin
            r_cnt[i_order] <= i_cnt;
        end
    end

    assign o_rdata = r_rdata;
    assign o_cnt   = cur;
    assign o_full  = full;

endmodule
`default_nettype wire

// ----- design/bfa_ctrl.sv -----
// Allocator sequencer: request decode, split, recycle, tidy sort/merge and counters.
// Depends on bfa_pkg, bfa_alu, bfa_stack and the assertion macro header.
`default_nettype none
`include "buddy_frame_allocator_unit_macros.svh"
module bfa_ctrl import bfa_pkg::*; #(
    parameter int MAX_ORDER   = MAX_ORDER_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int FRAME_BITS  = FRAME_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [TYPE_W-1:0]   i_type,
    input  logic [FRAME_W-1:0]  i_frame,
    input  logic [COUNT_W-1:0]  i_count,
    input  logic [CFG_W-1:0]    i_keep,
    input  logic [CFG_W-1:0]    i_tidy_int,
    input  logic                i_res_ready,
    output logic                o_idle,
    output logic                o_done,
    output t_status             o_status,
    output logic [FRAME_W-1:0]  o_frame,
    output logic [COUNT_W-1:0]  o_free
);

    localparam int NUM_ORD = MAX_ORDER + 1;
    localparam int OW      = $clog2(MAX_ORDER + 2);
    localparam int IW      = $clog2(STACK_DEPTH);
    localparam int CW      = $clog2(STACK_DEPTH + 1);
    localparam int FB      = FRAME_BITS;
    localparam int AW      = ((FB > COUNT_W) ? FB : COUNT_W) + 1;
    localparam int RW      = ((CW > CFG_W) ? CW : CFG_W) + 1;

    t_state               r_state, n_state;
    t_state               r_ret, n_ret;
    t_req                 r_type, n_type;
    t_status              r_status, n_status;
    logic [FB-1:0]        r_f, n_f;
    logic [FB-1:0]        r_p, n_p;
    logic [FB-1:0]        r_v, n_v;
    logic [FB-1:0]        r_a, n_a;
    logic [COUNT_W-1:0]   r_n, n_n;
    logic [COUNT_W-1:0]   r_n0, n_n0;
    logic [COUNT_W-1:0]   r_len, n_len;
    logic [COUNT_W-1:0]   r_ff, n_ff;
    logic [COUNT_W-1:0]   r_tot, n_tot;
    logic [OW-1:0]        r_o, n_o;
    logic [OW-1:0]        r_ord, n_ord;
    logic [OW-1:0]        r_src, n_src;
    logic [OW-1:0]        r_po, n_po;
    logic                 r_ovf, n_ovf;
    logic                 r_tidy, n_tidy;
    logic [CW-1:0]        r_i, n_i;
    logic [CW-1:0]        r_j, n_j;
    logic [CW-1:0]        r_m, n_m;
    logic [CW-1:0]        r_c, n_c;
    logic [CW-1:0]        r_rem, n_rem;
    logic [CFG_W-1:0]     r_calls [NUM_ORD];
    logic [CFG_W-1:0]     n_call_val;
    logic                 calls_we;

    logic [FB-1:0]        r_work [2 ** IW];
    logic [FB-1:0]        r_wrd;
    logic                 w_we;
    logic                 w_re;
    logic [IW-1:0]        w_waddr;
    logic [IW-1:0]        w_raddr;
    logic [FB-1:0]        w_wdata;

    t_stk_cmd             stk_cmd;
    logic [OW-1:0]        stk_order;
    logic [IW-1:0]        stk_idx;
    logic [FB-1:0]        stk_data;
    logic [CW-1:0]        stk_cnt_in;
    logic [FB-1:0]        stk_rdata;
    logic [CW-1:0]        stk_cnt;
    logic                 stk_full;

    t_alu_op              alu_op;
    logic [AW-1:0]        alu_a;
    logic [AW-1:0]        alu_b;
    logic [AW-1:0]        alu_y;

    logic [COUNT_W-1:0]   len_o;
    logic [COUNT_W-1:0]   len_om1;
    logic [COUNT_W-1:0]   len_srcm1;
    logic [COUNT_W-1:0]   len_ord;
    logic [COUNT_W-1:0]   big;
    logic [CW-1:0]        c_m1_j;
    logic [CW-1:0]        m_m1_j;
    logic [CW-1:0]        i_p1;
    logic [CW-1:0]        j_m1;
    logic [RW-1:0]        keep2;
    logic [CFG_W-1:0]     call_inc;
    logic                 merge_ok;

    bfa_stack #(
        .MAX_ORDER   (MAX_ORDER),
        .STACK_DEPTH (STACK_DEPTH),
        .FRAME_BITS  (FRAME_BITS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (stk_cmd),
        .i_order (stk_order),
        .i_idx   (stk_idx),
        .i_data  (stk_data),
        .i_cnt   (stk_cnt_in),
        .o_rdata (stk_rdata),
        .o_cnt   (stk_cnt),
        .o_full  (stk_full)
    );

    bfa_alu #(
        .AW (AW)
    ) u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y)
    );

    always_comb begin
        len_o     = COUNT_W'(1) << r_o;
        len_om1   = COUNT_W'(1) << (r_o - OW'(1));
        len_srcm1 = COUNT_W'(1) << (r_src - OW'(1));
        len_ord   = COUNT_W'(1) << r_ord;
        big       = COUNT_W'(1) << MAX_ORDER;
        c_m1_j    = r_c - CW'(1) - r_j;
        m_m1_j    = r_m - CW'(1) - r_j;
        i_p1      = r_i + CW'(1);
        j_m1      = r_j - CW'(1);
        keep2     = RW'(i_keep) + RW'(2);
        call_inc  = r_calls[r_ord] + CFG_W'(1);
        merge_ok  = (alu_y == AW'(r_wrd)) && ((AW'(r_a) & AW'(len_ord)) == '0);
    end

    // outputs: memory commands, ALU operands, handshake
    always_comb begin
        stk_cmd    = '0;
        stk_order  = r_ord;
        stk_idx    = '0;
        stk_data   = r_f;
        stk_cnt_in = r_m;
        alu_op     = ALU_ADD;
        alu_a      = AW'(r_f);
        alu_b      = AW'(r_len);
        w_we       = 1'b0;
        w_re       = 1'b0;
        w_waddr    = r_j[IW-1:0];
        w_raddr    = r_i[IW-1:0];
        w_wdata    = r_v;
        o_idle     = (r_state == S_IDLE);
        o_done     = 1'b0;
        case (r_state)
            S_SRCH: begin
                stk_order = r_src;
            end
            S_POP: begin
                stk_order   = r_src;
                stk_cmd.pop = 1'b1;
            end
            S_SPLIT: begin
                stk_order    = r_src - OW'(1);
                alu_a        = AW'(r_p);
                alu_b        = AW'(len_srcm1);
                stk_data     = alu_y[FB-1:0];
                stk_cmd.push = (r_src > r_ord);
            end
            S_TAIL1: begin
                alu_a = AW'(r_p);
                alu_b = AW'(r_n);
            end
            S_TAIL2: begin
                alu_op = ALU_SUB;
                alu_a  = AW'(len_ord);
                alu_b  = AW'(r_n);
            end
            S_PUSHF: begin
                stk_order    = r_po;
                stk_data     = r_f;
                stk_cmd.push = 1'b1;
            end
            S_SUBN: begin
                alu_op = ALU_SUB;
                alu_a  = AW'(r_n);
                alu_b  = AW'(r_len);
            end
            S_POST: begin
                alu_a = AW'(r_tot);
                alu_b = AW'(r_n0);
                if (r_type == REQ_ALLOC) begin
                    alu_op = ALU_SUB;
                    alu_a  = AW'(r_ff);
                end
            end
            S_POST2: begin
                alu_a = AW'(r_ff);
                alu_b = AW'(r_n0);
            end
            S_TC_RD: begin
                stk_idx    = c_m1_j[IW-1:0];
                stk_cmd.rd = (r_j < r_c);
            end
            S_TC_WR: begin
                w_we    = 1'b1;
                w_waddr = r_j[IW-1:0];
                w_wdata = stk_rdata;
            end
            S_TS_LD: begin
                w_re    = (r_i < r_c);
                w_raddr = r_i[IW-1:0];
            end
            S_TS_CMP: begin
                w_raddr = j_m1[IW-1:0];
                w_re    = (r_j != '0);
                w_we    = (r_j == '0);
                w_waddr = r_j[IW-1:0];
                w_wdata = r_v;
            end
            S_TS_CHK: begin
                w_we    = 1'b1;
                w_waddr = r_j[IW-1:0];
                w_wdata = (r_wrd > r_v) ? r_wrd : r_v;
            end
            S_TM_RD: begin
                w_raddr = r_i[IW-1:0];
                w_re    = (r_i < r_c) && (RW'(r_rem) >= keep2);
            end
            S_TM_A: begin
                w_raddr = i_p1[IW-1:0];
                w_re    = (i_p1 < r_c);
                w_we    = !(i_p1 < r_c);
                w_waddr = r_m[IW-1:0];
                w_wdata = r_wrd;
            end
            S_TM_B: begin
                stk_order    = r_ord + OW'(1);
                alu_a        = AW'(r_a);
                alu_b        = AW'(len_ord);
                stk_data     = r_a;
                stk_cmd.push = merge_ok;
                w_we         = !merge_ok;
                w_waddr      = r_m[IW-1:0];
                w_wdata      = r_a;
            end
            S_TR_RD: begin
                w_raddr = r_i[IW-1:0];
                w_re    = (r_i < r_c);
            end
            S_TR_WR: begin
                w_we    = 1'b1;
                w_waddr = r_m[IW-1:0];
                w_wdata = r_wrd;
            end
            S_TW_RD: begin
                w_raddr        = r_j[IW-1:0];
                w_re           = (r_j < r_m);
                stk_cnt_in     = r_m;
                stk_cmd.setcnt = !(r_j < r_m);
            end
            S_TW_WR: begin
                stk_idx    = m_m1_j[IW-1:0];
                stk_data   = r_wrd;
                stk_cmd.wr = 1'b1;
            end
            S_FIN: begin
                o_done = i_res_ready;
            end
            default: begin
            end
        endcase
    end

    // next state and register values
    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_type     = r_type;
        n_status   = r_status;
        n_f        = r_f;
        n_p        = r_p;
        n_v        = r_v;
        n_a        = r_a;
        n_n        = r_n;
        n_n0       = r_n0;
        n_len      = r_len;
        n_ff       = r_ff;
        n_tot      = r_tot;
        n_o        = r_o;
        n_ord      = r_ord;
        n_src      = r_src;
        n_po       = r_po;
        n_ovf      = r_ovf;
        n_tidy     = r_tidy;
        n_i        = r_i;
        n_j        = r_j;
        n_m        = r_m;
        n_c        = r_c;
        n_rem      = r_rem;
        n_call_val = call_inc;
        calls_we   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_type   = t_req'(i_type);
                    n_f      = FB'(i_frame);
                    n_n      = i_count;
                    n_n0     = i_count;
                    n_ovf    = 1'b0;
                    n_p      = '0;
                    n_o      = '0;
                    n_status = ST_OK;
                    if (t_req'(i_type) == REQ_NONE) begin
                        n_state = S_FIN;
                    end else if (i_count == '0) begin
                        n_status = ST_ZERO;
                        n_state  = S_FIN;
                    end else if (t_req'(i_type) == REQ_ALLOC && i_count > big) begin
                        n_status = ST_NOMEM;
                        n_state  = S_FIN;
                    end else if (t_req'(i_type) == REQ_ADD) begin
                        n_state = S_RC1;
                    end else begin
                        n_state = S_ORD;
                    end
                end
            end
            S_ORD: begin
                if (r_o < OW'(MAX_ORDER) && len_o < r_n0) begin
                    n_o = r_o + OW'(1);
                end else begin
                    n_ord = r_o;
                    n_src = r_o;
                    n_o   = '0;
                    n_state = (r_type == REQ_ALLOC) ? S_SRCH : S_RC1;
                end
            end
            S_SRCH: begin
                if (r_src > OW'(MAX_ORDER)) begin
                    n_status = ST_NOMEM;
                    n_state  = S_FIN;
                end else if (stk_cnt == '0) begin
                    n_src = r_src + OW'(1);
                end else begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                n_state = S_POPW;
            end
            S_POPW: begin
                n_p     = stk_rdata;
                n_state = S_SPLIT;
            end
            S_SPLIT: begin
                if (r_src > r_ord) begin
                    n_src = r_src - OW'(1);
                    n_ovf = r_ovf | stk_full;
                end else begin
                    n_state = S_TAIL1;
                end
            end
            S_TAIL1: begin
                if (len_ord > r_n) begin
                    n_f     = alu_y[FB-1:0];
                    n_state = S_TAIL2;
                end else begin
                    n_state = S_POST;
                end
            end
            S_TAIL2: begin
                n_n     = alu_y[COUNT_W-1:0];
                n_o     = '0;
                n_state = S_RC1;
            end
            S_RC1: begin
                if (r_n != '0 && len_o <= r_n && r_o < OW'(MAX_ORDER)) begin
                    n_o = r_o + OW'(1);
                    if ((AW'(r_f) & AW'(len_o)) != '0) begin
                        n_po    = r_o;
                        n_len   = len_o;
                        n_ret   = S_RC1;
                        n_state = S_PUSHF;
                    end
                end else begin
                    n_state = S_RC2;
                end
            end
            S_RC2: begin
                if (r_n >= big) begin
                    n_po    = OW'(MAX_ORDER);
                    n_len   = big;
                    n_ret   = S_RC2;
                    n_state = S_PUSHF;
                end else begin
                    n_o     = OW'(MAX_ORDER);
                    n_state = S_RC3;
                end
            end
            S_RC3: begin
                if (r_o != '0 && r_n != '0) begin
                    n_o = r_o - OW'(1);
                    if ((r_n & len_om1) != '0) begin
                        n_po    = r_o - OW'(1);
                        n_len   = len_om1;
                        n_ret   = S_RC3;
                        n_state = S_PUSHF;
                    end
                end else begin
                    n_state = S_POST;
                end
            end
            S_PUSHF: begin
                n_ovf   = r_ovf | stk_full;
                n_f     = alu_y[FB-1:0];
                n_state = S_SUBN;
            end
            S_SUBN: begin
                n_n     = alu_y[COUNT_W-1:0];
                n_state = r_ret;
            end
            S_POST: begin
                case (r_type)
                    REQ_ALLOC: begin
                        n_ff    = alu_y[AW-1] ? '0 : alu_y[COUNT_W-1:0];
                        n_state = S_FIN;
                    end
                    REQ_FREE: begin
                        calls_we = 1'b1;
                        if (call_inc == i_tidy_int) begin
                            n_call_val = '0;
                            n_tidy     = (r_ord < OW'(MAX_ORDER));
                        end else begin
                            n_tidy = 1'b0;
                        end
                        n_state = S_POST2;
                    end
                    default: begin
                        n_tot   = (alu_y[AW-1:COUNT_W] != '0) ? '1 : alu_y[COUNT_W-1:0];
                        n_state = S_POST2;
                    end
                endcase
            end
            S_POST2: begin
                n_ff = (alu_y[AW-1:COUNT_W] != '0) ? '1 : alu_y[COUNT_W-1:0];
                n_c  = stk_cnt;
                n_j  = '0;
                n_state = (r_type == REQ_FREE && r_tidy) ? S_TC_RD : S_FIN;
            end
            S_TC_RD: begin
                if (r_j < r_c) begin
                    n_state = S_TC_WR;
                end else begin
                    n_i     = CW'(1);
                    n_state = S_TS_LD;
                end
            end
            S_TC_WR: begin
                n_j     = r_j + CW'(1);
                n_state = S_TC_RD;
            end
            S_TS_LD: begin
                if (r_i < r_c) begin
                    n_state = S_TS_V;
                end else begin
                    n_i     = '0;
                    n_m     = '0;
                    n_rem   = r_c;
                    n_state = S_TM_RD;
                end
            end
            S_TS_V: begin
                n_v     = r_wrd;
                n_j     = r_i;
                n_state = S_TS_CMP;
            end
            S_TS_CMP: begin
                if (r_j != '0) begin
                    n_state = S_TS_CHK;
                end else begin
                    n_i     = i_p1;
                    n_state = S_TS_LD;
                end
            end
            S_TS_CHK: begin
                if (r_wrd > r_v) begin
                    n_j     = j_m1;
                    n_state = S_TS_CMP;
                end else begin
                    n_i     = i_p1;
                    n_state = S_TS_LD;
                end
            end
            S_TM_RD: begin
                n_state = ((r_i < r_c) && (RW'(r_rem) >= keep2)) ? S_TM_A : S_TR_RD;
            end
            S_TM_A: begin
                n_a = r_wrd;
                if (i_p1 < r_c) begin
                    n_state = S_TM_B;
                end else begin
                    n_m     = r_m + CW'(1);
                    n_i     = i_p1;
                    n_state = S_TM_RD;
                end
            end
            S_TM_B: begin
                if (merge_ok) begin
                    n_ovf = r_ovf | stk_full;
                    n_rem = r_rem - CW'(2);
                    n_i   = r_i + CW'(2);
                end else begin
                    n_m = r_m + CW'(1);
                    n_i = i_p1;
                end
                n_state = S_TM_RD;
            end
            S_TR_RD: begin
                if (r_i < r_c) begin
                    n_state = S_TR_WR;
                end else begin
                    n_j     = '0;
                    n_state = S_TW_RD;
                end
            end
            S_TR_WR: begin
                n_m     = r_m + CW'(1);
                n_i     = i_p1;
                n_state = S_TR_RD;
            end
            S_TW_RD: begin
                n_state = (r_j < r_m) ? S_TW_WR : S_FIN;
            end
            S_TW_WR: begin
                n_j     = r_j + CW'(1);
                n_state = S_TW_RD;
            end
            S_FIN: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_work[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_wrd <= r_work[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ff    <= '0;
            r_tot   <= '0;
            for (int k = 0; k < NUM_ORD; k++) begin
                r_calls[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_ff    <= n_ff;
            r_tot   <= n_tot;
            if (calls_we) begin
                r_calls[r_ord] <= n_call_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret    <= n_ret;
        r_type   <= n_type;
        r_status <= n_status;
        r_f      <= n_f;
        r_p      <= n_p;
        r_v      <= n_v;
        r_a      <= n_a;
        r_n      <= n_n;
        r_n0     <= n_n0;
        r_len    <= n_len;
        r_o      <= n_o;
        r_ord    <= n_ord;
        r_src    <= n_src;
        r_po     <= n_po;
        r_ovf    <= n_ovf;
        r_tidy   <= n_tidy;
        r_i      <= n_i;
        r_j      <= n_j;
        r_m      <= n_m;
        r_c      <= n_c;
        r_rem    <= n_rem;
    end

    assign o_status = (r_status == ST_OK && r_ovf) ? ST_OVF : r_status;
    assign o_frame  = FRAME_W'(r_p);
    assign o_free   = r_ff;

    `BFA_ASSERT_IMP(a_pop_nonempty, stk_cmd.pop, stk_cnt != '0, "pop from an empty stack")
    `BFA_ASSERT_IMP(a_sort_index, r_state == S_TS_CMP || r_state == S_TS_CHK, r_j <= r_i, "sort index past insert point")
    `BFA_ASSERT_IMP(a_merge_keep, r_state == S_TM_RD || r_state == S_TR_RD, r_m <= r_i, "compaction overtook read index")
    `BFA_ASSERT_NXT(a_done_idle, o_done, r_state == S_IDLE, "result transfer without return to idle")

endmodule
`default_nettype wire

// ----- tb/bfa_checker.sv -----
// Checker for the buddy frame allocator: watches the APB port and both streams,
// predicts each result from its own copy of the allocator state and compares.
// Depends on bfa_pkg; instantiated beside the block by the testbench top.
module bfa_checker import bfa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [TDATA_W-1:0]  s_axis_tdata,   // frame[19:0], count[40:20], zero[47:41]
    input  logic [TYPE_W-1:0]   s_axis_tuser,   // req_type[1:0]
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [TDATA_W-1:0]  m_axis_tdata,   // frame_out[19:0], frames_free[40:20], zero[47:41]
    input  logic [STATUS_W-1:0] m_axis_tuser,   // status[1:0]
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    input  logic                pready,
    output int                  o_errors,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NORD = MAX_ORDER_DEF + 1;
    localparam int DEPTH = STACK_DEPTH_DEF;
    localparam longint FMASK = (64'd1 << FRAME_W) - 1;
    localparam longint CMAX = (64'd1 << COUNT_W) - 1;

    typedef struct packed {
        t_status            status;
        logic [FRAME_W-1:0] frame_out;
        logic [COUNT_W-1:0] frames_free;
    } t_result;

    logic [FRAME_W-1:0] free_blocks [NORD][DEPTH];
    int unsigned        depth_of [NORD];
    logic [7:0]         frees_seen [NORD];
    longint             free_frames;
    longint             total_frames;
    logic [CFG_W-1:0]   keep_min;
    logic [CFG_W-1:0]   tidy_every;
    bit                 push_dropped;
    longint             sort_buf [DEPTH];
    t_result            expected_results [$];

    function automatic void push_free(int o, longint f);
        if (depth_of[o] >= DEPTH) begin
            push_dropped = 1'b1;
            return;
        end
        free_blocks[o][depth_of[o]] = f[FRAME_W-1:0];
        depth_of[o]++;
    endfunction

    function automatic void release_run(longint f, longint n);
        int o;
        longint len;
        longint big;
        o = 0;
        big = 64'd1 << MAX_ORDER_DEF;
        while (n > 0 && (64'd1 << o) <= n && o < MAX_ORDER_DEF) begin
            len = 64'd1 << o;
            if ((f & len) != 0) begin
                push_free(o, f);
                f = (f + len) & FMASK;
                n -= len;
            end
            o++;
        end
        while (n >= big) begin
            push_free(MAX_ORDER_DEF, f);
            f = (f + big) & FMASK;
            n -= big;
        end
        o = MAX_ORDER_DEF;
        while (o > 0 && n > 0) begin
            o--;
            len = 64'd1 << o;
            if ((n & len) != 0) begin
                push_free(o, f);
                f = (f + len) & FMASK;
                n -= len;
            end
        end
    endfunction

    function automatic void tidy_order(int o);
        int c, i, j, m, rem;
        longint v, len;
        if (o >= MAX_ORDER_DEF) return;
        c = depth_of[o];
        for (j = 0; j < c; j++) sort_buf[j] = free_blocks[o][c-1-j];
        for (i = 1; i < c; i++) begin
            v = sort_buf[i];
            j = i;
            while (j > 0 && sort_buf[j-1] > v) begin
                sort_buf[j] = sort_buf[j-1];
                j--;
            end
            sort_buf[j] = v;
        end
        len = 64'd1 << o;
        rem = c;
        i = 0;
        m = 0;
        while (i < c && rem >= int'(keep_min) + 2) begin
            if (i + 1 < c && sort_buf[i] + len == sort_buf[i+1] && (sort_buf[i] & len) == 0) begin
                push_free(o + 1, sort_buf[i]);
                rem -= 2;
                i += 2;
            end else begin
                sort_buf[m] = sort_buf[i];
                m++;
                i++;
            end
        end
        while (i < c) begin
            sort_buf[m] = sort_buf[i];
            m++;
            i++;
        end
        for (j = 0; j < m; j++) free_blocks[o][m-1-j] = sort_buf[j][FRAME_W-1:0];
        depth_of[o] = m;
    endfunction

    function automatic int order_of(longint n);
        int o;
        o = 0;
        while (o < MAX_ORDER_DEF && (64'd1 << o) < n) o++;
        return o;
    endfunction

    function automatic longint sat_sum(longint a, longint b);
        return (a + b > CMAX) ? CMAX : a + b;
    endfunction

    function automatic t_result allocate_request(t_req kind, longint f, longint n);
        t_result r;
        int ord, src;
        longint p;
        r = '0;
        r.status = ST_OK;
        push_dropped = 1'b0;
        if (kind != REQ_NONE && n == 0) begin
            r.status = ST_ZERO;
        end else if (kind == REQ_ALLOC) begin
            if (n > (64'd1 << MAX_ORDER_DEF)) begin
                r.status = ST_NOMEM;
            end else begin
                ord = order_of(n);
                src = ord;
                while (src <= MAX_ORDER_DEF && depth_of[src] == 0) src++;
                if (src > MAX_ORDER_DEF) begin
                    r.status = ST_NOMEM;
                end else begin
                    depth_of[src]--;
                    p = free_blocks[src][depth_of[src]];
                    while (src > ord) begin
                        src--;
                        push_free(src, p + (64'd1 << src));
                    end
                    if ((64'd1 << ord) > n) release_run((p + n) & FMASK, (64'd1 << ord) - n);
                    free_frames = free_frames > n ? free_frames - n : 0;
                    r.frame_out = p[FRAME_W-1:0];
                    r.status = push_dropped ? ST_OVF : ST_OK;
                end
            end
        end else if (kind == REQ_FREE) begin
            release_run(f, n);
            ord = order_of(n);
            frees_seen[ord] = frees_seen[ord] + 8'd1;
            if (frees_seen[ord] == tidy_every) begin
                tidy_order(ord);
                frees_seen[ord] = '0;
            end
            free_frames = sat_sum(free_frames, n);
            r.status = push_dropped ? ST_OVF : ST_OK;
        end else if (kind == REQ_ADD) begin
            release_run(f, n);
            total_frames = sat_sum(total_frames, n);
            free_frames = sat_sum(free_frames, n);
            r.status = push_dropped ? ST_OVF : ST_OK;
        end
        r.frames_free = free_frames[COUNT_W-1:0];
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_result want, got;
        if (!i_rst_n) begin
            for (int o = 0; o < NORD; o++) begin
                depth_of[o] = 0;
                frees_seen[o] = '0;
            end
            free_frames = 0;
            total_frames = 0;
            keep_min = KEEP_RESET;
            tidy_every = TIDY_RESET;
            expected_results.delete();
            o_errors <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[REG_LSB] == REG_KEEP) keep_min = pwdata[CFG_W-1:0];
                else tidy_every = pwdata[CFG_W-1:0];
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(allocate_request(t_req'(s_axis_tuser),
                    longint'(s_axis_tdata[FRAME_W-1:0]),
                    longint'(s_axis_tdata[FRAME_W +: COUNT_W])));
            if (m_axis_tvalid && m_axis_tready) begin
                got.status = t_status'(m_axis_tuser);
                got.frame_out = m_axis_tdata[FRAME_W-1:0];
                got.frames_free = m_axis_tdata[FRAME_W +: COUNT_W];
                if (expected_results.size() == 0) begin
                    if (o_errors < 10) $display("unexpected transfer: status %0d frame %0h free %0d",
                        got.status, got.frame_out, got.frames_free);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want != got || m_axis_tdata[TDATA_W-1:FRAME_W+COUNT_W] != '0) begin
                        if (o_errors < 10)
                            $display("mismatch: exp status %0d frame %0h free %0d, got %0d %0h %0d",
                                want.status, want.frame_out, want.frames_free,
                                got.status, got.frame_out, got.frames_free);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- tb/testbench.sv -----
// Testbench top for buddy_frame_allocator_unit: clock, reset, APB setup and
// request stimulus; bfa_checker predicts and compares the results.
// Depends on bfa_pkg, bfa_checker and the allocator RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bfa_pkg::*;

    localparam longint CYCLE_LIMIT = 30_000_000;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [TDATA_W-1:0]  s_axis_tdata;
    logic [TYPE_W-1:0]   s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic [STATUS_W-1:0] m_axis_tuser;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    int                  errors;
    int                  pending;
    int                  hold_off_cycles;
    longint              cycles;

    buddy_frame_allocator_unit u_top (.*);

    bfa_checker u_chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= APB_AW'(idx) << REG_LSB;
        pwdata <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_request(input t_req kind, input logic [FRAME_W-1:0] frame,
                                input logic [COUNT_W-1:0] count);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {7'd0, count, frame};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_results;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic random_requests(input int num);
        int r;
        logic [COUNT_W-1:0] n;
        for (int k = 0; k < num; k++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                n = ($urandom_range(0, 9) == 0) ? COUNT_W'($urandom_range(1, 1100))
                                                : COUNT_W'($urandom_range(1, 40));
                send_request(REQ_ALLOC, '0, n);
            end else if (r < 85) begin
                send_request(REQ_FREE, FRAME_W'($urandom_range(0, 16383)),
                             COUNT_W'($urandom_range(1, 40)));
            end else if (r < 91) begin
                send_request(REQ_ADD, FRAME_W'($urandom_range(0, 16383)),
                             COUNT_W'($urandom_range(1, 3000)));
            end else if (r < 94) begin
                send_request(t_req'($urandom_range(0, 2)), FRAME_W'($urandom), '0);
            end else if (r < 96) begin
                send_request(REQ_NONE, FRAME_W'($urandom), COUNT_W'($urandom));
            end else begin
                send_request(t_req'($urandom_range(0, 2)), FRAME_W'($urandom),
                             COUNT_W'($urandom_range(1, 5000)));
            end
        end
    endtask

    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = $urandom_range(0, 7);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (hold_off_cycles > 0) begin
                stall = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        cycles = 0;
        hold_off_cycles = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = REQ_ALLOC;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(REG_KEEP, 8'd0);
        write_reg(REG_TIDY, 8'd1);
        send_request(REQ_ALLOC, '0, 21'd1);
        send_request(REQ_ADD, 20'd0, 21'd8192);
        send_request(REQ_ALLOC, '0, '0);
        send_request(REQ_FREE, 20'd5, '0);
        send_request(REQ_ADD, 20'd7, '0);
        send_request(REQ_ALLOC, '0, 21'd1025);
        send_request(REQ_ALLOC, '0, 21'd1);
        send_request(REQ_ALLOC, '0, 21'd3);
        send_request(REQ_ALLOC, '0, 21'd1024);
        send_request(REQ_ALLOC, '0, 21'd700);
        send_request(REQ_FREE, 20'd1, 21'd1);
        send_request(REQ_FREE, 20'd0, 21'd1);
        send_request(REQ_FREE, 20'd4, 21'd3);
        send_request(REQ_FREE, 20'hFFF00, 21'd2000);
        send_request(REQ_NONE, 20'hFFFFF, 21'h1FFFFF);
        send_request(REQ_ADD, 20'hFFFFF, 21'h100000);
        send_request(REQ_ADD, 20'h80000, 21'h100000);
        send_request(REQ_ALLOC, '0, 21'd5);
        drain_results();

        hold_off_cycles = 400;
        random_requests(140);
        drain_results();
        write_reg(REG_KEEP, 8'd255);
        write_reg(REG_TIDY, 8'd255);
        random_requests(130);
        drain_results();
        write_reg(REG_KEEP, 8'd3);
        write_reg(REG_TIDY, 8'd4);
        random_requests(130);
        drain_results();
        write_reg(REG_KEEP, 8'd8);
        write_reg(REG_TIDY, 8'd32);
        random_requests(130);
        drain_results();

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
